@@ design/mwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared widths, wheel indexes and the control bundle that travels with each
// request through the pipeline.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // Default fraction bits of a command (Q1.15).
  localparam int DEF_CMD_FRAC_BITS = 15;

  // Fixed field widths.
  localparam int CMD_W      = 16;
  localparam int SUM_W      = CMD_W + 2;   // three commands added
  localparam int MAG_W      = CMD_W + 1;   // magnitude of a sum, at most 3 * 2^15
  localparam int QUOT_W     = 8;           // level magnitude 0..255
  localparam int LEVEL_W    = QUOT_W + 1;  // signed drive level
  localparam int NUM_WHEELS = 4;

  // Pipeline depth from request accept to result strobe.
  localparam int MIX_STAGES   = 3;
  localparam int PIPE_LATENCY = MIX_STAGES + QUOT_W + 1;

  // Wheel order inside every per-wheel vector.
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_BL = 2;
  localparam int WHEEL_BR = 3;

  // Control that moves along with a request.
  typedef struct packed {
    logic                  valid;
    logic [NUM_WHEELS-1:0] neg;
  } stage_ctrl_t;

endpackage

@@ design/mwm_mix.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer front end
// Three stages: wheel sums, magnitudes with pairwise maxima, then the peak
// with its floor and the scaled dividends (magnitude times 255).
// ----------------------------------------------------------------------------
module mwm_mix #(
  parameter int CMD_FRAC_BITS = mwm_pkg::DEF_CMD_FRAC_BITS,
  localparam int PEAK_W = (CMD_FRAC_BITS + 1 > mwm_pkg::MAG_W) ?
                          CMD_FRAC_BITS + 1 : mwm_pkg::MAG_W,
  localparam int PROD_W = PEAK_W + mwm_pkg::QUOT_W
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic signed [mwm_pkg::CMD_W-1:0]        forward_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]        strafe_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]        turn_cmd,
  output mwm_pkg::stage_ctrl_t                    ctrl_out,
  output logic [PEAK_W-1:0]                       peak_out,
  output logic [PROD_W-1:0]                       prod_out [mwm_pkg::NUM_WHEELS]
);

  localparam int NW = mwm_pkg::NUM_WHEELS;

  // Stage 1 registers.
  logic                               valid1;
  logic signed [mwm_pkg::SUM_W-1:0]   sum1 [NW];

  // Stage 2 registers.
  logic                               valid2;
  logic [NW-1:0]                      neg2;
  logic [mwm_pkg::MAG_W-1:0]          mag2 [NW];
  logic [mwm_pkg::MAG_W-1:0]          max01;
  logic [mwm_pkg::MAG_W-1:0]          max23;

  // Extended command values.
  logic signed [mwm_pkg::SUM_W-1:0]   x_ext;
  logic signed [mwm_pkg::SUM_W-1:0]   y_ext;
  logic signed [mwm_pkg::SUM_W-1:0]   z_ext;
  logic signed [mwm_pkg::SUM_W-1:0]   abs_sum [NW];
  logic [PEAK_W-1:0]                  peak_floor;
  logic [PEAK_W-1:0]                  max_a;
  logic [PEAK_W-1:0]                  max_b;
  logic [PEAK_W-1:0]                  peak_next;

  assign x_ext = mwm_pkg::SUM_W'(forward_cmd);
  assign y_ext = mwm_pkg::SUM_W'(strafe_cmd);
  assign z_ext = mwm_pkg::SUM_W'(turn_cmd);

  // Stage 1: the four wheel sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    sum1[mwm_pkg::WHEEL_FL] <= x_ext + y_ext + z_ext;
    sum1[mwm_pkg::WHEEL_FR] <= x_ext - y_ext - z_ext;
    sum1[mwm_pkg::WHEEL_BL] <= x_ext - y_ext + z_ext;
    sum1[mwm_pkg::WHEEL_BR] <= x_ext + y_ext - z_ext;
  end

  // Absolute value of each sum; the largest magnitude fits in MAG_W bits.
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      abs_sum[w] = sum1[w][mwm_pkg::SUM_W-1] ? -sum1[w] : sum1[w];
    end
  end

  // Stage 2: magnitudes, signs and the first level of the maximum tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
    for (int w = 0; w < NW; w++) begin
      mag2[w] <= abs_sum[w][mwm_pkg::MAG_W-1:0];
      neg2[w] <= sum1[w][mwm_pkg::SUM_W-1];
    end
    max01 <= (abs_sum[0][mwm_pkg::MAG_W-1:0] > abs_sum[1][mwm_pkg::MAG_W-1:0]) ?
             abs_sum[0][mwm_pkg::MAG_W-1:0] : abs_sum[1][mwm_pkg::MAG_W-1:0];
    max23 <= (abs_sum[2][mwm_pkg::MAG_W-1:0] > abs_sum[3][mwm_pkg::MAG_W-1:0]) ?
             abs_sum[2][mwm_pkg::MAG_W-1:0] : abs_sum[3][mwm_pkg::MAG_W-1:0];
  end

  // Final peak: the larger pair maximum, never below 1.0.
  assign peak_floor = {{(PEAK_W-1){1'b0}}, 1'b1} << CMD_FRAC_BITS;
  assign max_a      = PEAK_W'(max01);
  assign max_b      = PEAK_W'(max23);
  always_comb begin
    peak_next = (max_a > max_b) ? max_a : max_b;
    if (peak_floor > peak_next) begin
      peak_next = peak_floor;
    end
  end

  // Stage 3: peak and dividends mag * 255 = (mag << 8) - mag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= valid2;
    end
    ctrl_out.neg <= neg2;
    peak_out     <= peak_next;
    for (int w = 0; w < NW; w++) begin
      prod_out[w] <= (PROD_W'(mag2[w]) << mwm_pkg::QUOT_W) - PROD_W'(mag2[w]);
    end
  end

`ifndef SYNTHESIS
  // The peak never drops below the 1.0 floor.
  a_peak_floor: assert property (@(posedge clk) disable iff (rst)
    ctrl_out.valid |-> (peak_out >= peak_floor))
    else $error("peak below floor");

  // Every dividend is at most 255 times the peak, so the quotient fits 8 bits.
  a_prod_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl_out.valid |->
      (prod_out[0] <= (PROD_W'(peak_out) << mwm_pkg::QUOT_W) - PROD_W'(peak_out)) &&
      (prod_out[1] <= (PROD_W'(peak_out) << mwm_pkg::QUOT_W) - PROD_W'(peak_out)) &&
      (prod_out[2] <= (PROD_W'(peak_out) << mwm_pkg::QUOT_W) - PROD_W'(peak_out)) &&
      (prod_out[3] <= (PROD_W'(peak_out) << mwm_pkg::QUOT_W) - PROD_W'(peak_out)))
    else $error("dividend exceeds 255 times peak");

  // A negative sum always has a nonzero magnitude.
  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid2 |-> ((!neg2[0] || mag2[0] != '0) && (!neg2[1] || mag2[1] != '0) &&
                (!neg2[2] || mag2[2] != '0) && (!neg2[3] || mag2[3] != '0)))
    else $error("negative sum with zero magnitude");
`endif

endmodule

@@ design/mwm_div.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer divider
// Pipelined restoring divider, four lanes sharing one divisor (the peak).
// Each stage settles one quotient bit, most significant first.
// ----------------------------------------------------------------------------
module mwm_div #(
  parameter int CMD_FRAC_BITS = mwm_pkg::DEF_CMD_FRAC_BITS,
  localparam int PEAK_W = (CMD_FRAC_BITS + 1 > mwm_pkg::MAG_W) ?
                          CMD_FRAC_BITS + 1 : mwm_pkg::MAG_W,
  localparam int PROD_W = PEAK_W + mwm_pkg::QUOT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mwm_pkg::stage_ctrl_t        ctrl_in,
  input  logic [PEAK_W-1:0]           peak_in,
  input  logic [PROD_W-1:0]           prod_in [mwm_pkg::NUM_WHEELS],
  output mwm_pkg::stage_ctrl_t        ctrl_out,
  output logic [mwm_pkg::QUOT_W-1:0]  quot_out [mwm_pkg::NUM_WHEELS]
);

  localparam int NW = mwm_pkg::NUM_WHEELS;
  localparam int QW = mwm_pkg::QUOT_W;

  // Stage 0 is the input; stage QW holds the finished quotients.
  mwm_pkg::stage_ctrl_t ctrl_s [QW+1];
  logic [PEAK_W-1:0]    peak_s [QW+1];
  logic [PROD_W-1:0]    rem_s  [QW+1][NW];
  logic [QW-1:0]        quot_s [QW+1][NW];

  assign ctrl_s[0] = ctrl_in;
  assign peak_s[0] = peak_in;
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      rem_s[0][w]  = prod_in[w];
      quot_s[0][w] = '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SHIFT = QW - 1 - s;

    logic [PROD_W-1:0] dshift;
    logic [PROD_W:0]   trial [NW];

    // Trial subtraction of the shifted divisor in every lane.
    assign dshift = PROD_W'(peak_s[s]) << SHIFT;
    always_comb begin
      for (int w = 0; w < NW; w++) begin
        trial[w] = {1'b0, rem_s[s][w]} - {1'b0, dshift};
      end
    end

    // Keep the difference when it did not borrow and record the bit.
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_s[s+1].valid <= 1'b0;
      end else begin
        ctrl_s[s+1].valid <= ctrl_s[s].valid;
      end
      ctrl_s[s+1].neg <= ctrl_s[s].neg;
      peak_s[s+1]     <= peak_s[s];
      for (int w = 0; w < NW; w++) begin
        if (!trial[w][PROD_W]) begin
          rem_s[s+1][w] <= trial[w][PROD_W-1:0];
        end else begin
          rem_s[s+1][w] <= rem_s[s][w];
        end
        quot_s[s+1][w] <= {quot_s[s][w][QW-2:0], !trial[w][PROD_W]};
      end
    end
  end

  assign ctrl_out = ctrl_s[QW];
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      quot_out[w] = quot_s[QW][w];
    end
  end

`ifndef SYNTHESIS
  // After the last stage every remainder is below the divisor.
  a_rem_below_peak: assert property (@(posedge clk) disable iff (rst)
    ctrl_s[QW].valid |->
      (rem_s[QW][0] < PROD_W'(peak_s[QW])) && (rem_s[QW][1] < PROD_W'(peak_s[QW])) &&
      (rem_s[QW][2] < PROD_W'(peak_s[QW])) && (rem_s[QW][3] < PROD_W'(peak_s[QW])))
    else $error("divider remainder not reduced");

  // A zero dividend gives a zero quotient.
  a_zero_quot: assert property (@(posedge clk) disable iff (rst)
    (ctrl_s[0].valid && rem_s[0][0] == '0) |-> ##8 (quot_s[QW][0] == '0))
    else $error("zero dividend gave nonzero quotient");

  // The divisor is never zero while a request is in the divider.
  a_peak_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl_s[QW].valid |-> (peak_s[QW] != '0))
    else $error("zero divisor");
`endif

endmodule

@@ design/mecanum_wheel_mixer_top.sv @@
// Path: a request accepted at one clock edge shows its result with done high
// after 3 mixing stages, 8 divider stages and 1 output register.
// Throughput: one request per cycle; busy is always low and the pipeline never stalls.
// The latency is set mostly by the 8-stage restoring divider, one quotient bit per stage.
// Reset (rst, synchronous) clears all valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
// Mecanum wheel mixer top level
// Mixes forward, strafe and turn commands into four wheel levels normalized
// to the largest wheel magnitude (floor 1.0) and scaled to -255..255.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top #(
  parameter int CMD_FRAC_BITS = mwm_pkg::DEF_CMD_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mwm_pkg::CMD_W-1:0]     forward_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]     strafe_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]     turn_cmd,
  output logic                                 done,
  output logic signed [mwm_pkg::LEVEL_W-1:0]   front_left_level,
  output logic signed [mwm_pkg::LEVEL_W-1:0]   front_right_level,
  output logic signed [mwm_pkg::LEVEL_W-1:0]   back_left_level,
  output logic signed [mwm_pkg::LEVEL_W-1:0]   back_right_level
);

  localparam int PEAK_W = (CMD_FRAC_BITS + 1 > mwm_pkg::MAG_W) ?
                          CMD_FRAC_BITS + 1 : mwm_pkg::MAG_W;
  localparam int PROD_W = PEAK_W + mwm_pkg::QUOT_W;
  localparam int NW     = mwm_pkg::NUM_WHEELS;

  mwm_pkg::stage_ctrl_t         mix_ctrl;
  logic [PEAK_W-1:0]            mix_peak;
  logic [PROD_W-1:0]            mix_prod [NW];
  mwm_pkg::stage_ctrl_t         div_ctrl;
  logic [mwm_pkg::QUOT_W-1:0]   div_quot [NW];
  logic [mwm_pkg::LEVEL_W-1:0]  level_next [NW];

  // The pipeline takes a request every cycle.
  assign busy = 1'b0;

  mwm_mix #(
    .CMD_FRAC_BITS (CMD_FRAC_BITS)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .forward_cmd (forward_cmd),
    .strafe_cmd  (strafe_cmd),
    .turn_cmd    (turn_cmd),
    .ctrl_out    (mix_ctrl),
    .peak_out    (mix_peak),
    .prod_out    (mix_prod)
  );

  mwm_div #(
    .CMD_FRAC_BITS (CMD_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (mix_ctrl),
    .peak_in  (mix_peak),
    .prod_in  (mix_prod),
    .ctrl_out (div_ctrl),
    .quot_out (div_quot)
  );

  // Apply each wheel's sign to its quotient; truncation is toward zero.
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      level_next[w] = div_ctrl.neg[w] ? -{1'b0, div_quot[w]} : {1'b0, div_quot[w]};
    end
  end

  // Output register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_ctrl.valid;
    end
    front_left_level  <= level_next[mwm_pkg::WHEEL_FL];
    front_right_level <= level_next[mwm_pkg::WHEEL_FR];
    back_left_level   <= level_next[mwm_pkg::WHEEL_BL];
    back_right_level  <= level_next[mwm_pkg::WHEEL_BR];
  end

`ifndef SYNTHESIS
  // Every accepted request produces a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(mwm_pkg::PIPE_LATENCY) done)
    else $error("result missing after pipeline latency");

  // Levels never reach -256.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (front_left_level != 9'sh100) && (front_right_level != 9'sh100) &&
             (back_left_level != 9'sh100) && (back_right_level != 9'sh100))
    else $error("drive level out of range");

  // A zero command gives four zero levels.
  a_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && forward_cmd == '0 && strafe_cmd == '0 && turn_cmd == '0) |->
      ##(mwm_pkg::PIPE_LATENCY)
      (front_left_level == '0 && front_right_level == '0 &&
       back_left_level == '0 && back_right_level == '0))
    else $error("zero command gave nonzero level");
`endif

endmodule
